// ----- rtl/cpf_pkg.sv -----
`timescale 1ns / 1ps

package cpf_pkg;

  localparam int unsigned CPF_FIFO_DEPTH = 4;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  SYNC_0   = 8'hA5;
  localparam logic [7:0]  SYNC_1   = 8'h5A;

  // configuration register indexes
  localparam logic [1:0] REG_VERSION     = 2'd0;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd1;
  localparam logic [1:0] REG_CRC_SEED    = 2'd2;

  localparam logic [7:0]  RST_VERSION     = 8'd1;
  localparam logic [15:0] RST_MAX_PAYLOAD = 16'd256;
  localparam logic [15:0] RST_CRC_SEED    = 16'hFFFF;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_LEN_LARGE = 2'd1;
  localparam logic [1:0] STATUS_NO_FRAME  = 2'd2;

  // input kind codes
  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // word positions inside one command
  localparam logic [3:0] POS_SYNC_1   = 4'd1;
  localparam logic [3:0] POS_HDR_LAST = 4'd13;
  localparam logic [3:0] POS_HDR_CRCL = 4'd14;
  localparam logic [3:0] POS_HDR_CRCH = 4'd15;
  localparam logic [3:0] POS_DAT_BYTE = 4'd0;
  localparam logic [3:0] POS_DAT_CRCL = 4'd1;
  localparam logic [3:0] POS_DAT_CRCH = 4'd2;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_DATA,
    CMD_ERR_LEN,
    CMD_ERR_FRAME
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    logic        crc_after;
    logic [7:0]  message_type;
    logic [31:0] sequence_req;
    logic [31:0] timestamp_ms;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
  } cmd_t;

  // crc-16, poly 0x1021, msb first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/cpf_front.sv -----
`timescale 1ns / 1ps

module cpf_front
  import cpf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  message_type_i,
  input  logic [31:0] sequence_req_i,
  input  logic [31:0] timestamp_ms_i,
  input  logic [15:0] payload_length_i,
  input  logic [7:0]  payload_byte_i,
  input  logic [15:0] max_payload_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output cmd_t        q_cmd_o
);

  logic        in_frame_q, in_frame_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [15:0] bytes_left_dec;
  logic        accept;

  assign in_ready_o     = !q_full_i;
  assign accept         = in_valid_i && !q_full_i;
  assign q_push_o       = accept;
  assign bytes_left_dec = bytes_left_q - 16'd1;

  always_comb begin
    in_frame_d             = in_frame_q;
    bytes_left_d           = bytes_left_q;
    q_cmd_o.op             = CMD_DATA;
    q_cmd_o.crc_after      = 1'b0;
    q_cmd_o.message_type   = message_type_i;
    q_cmd_o.sequence_req   = sequence_req_i;
    q_cmd_o.timestamp_ms   = timestamp_ms_i;
    q_cmd_o.payload_length = payload_length_i;
    q_cmd_o.payload_byte   = payload_byte_i;
    if (kind_i == KIND_START) begin
      if (payload_length_i > max_payload_i) begin
        q_cmd_o.op = CMD_ERR_LEN;
      end else begin
        q_cmd_o.op        = CMD_START;
        q_cmd_o.crc_after = (payload_length_i == 16'd0);
        if (accept) begin
          in_frame_d   = (payload_length_i != 16'd0);
          bytes_left_d = payload_length_i;
        end
      end
    end else begin
      if (!in_frame_q) begin
        q_cmd_o.op = CMD_ERR_FRAME;
      end else begin
        q_cmd_o.op        = CMD_DATA;
        q_cmd_o.crc_after = (bytes_left_dec == 16'd0);
        if (accept) begin
          bytes_left_d = bytes_left_dec;
          in_frame_d   = (bytes_left_dec != 16'd0);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q   <= 1'b0;
      bytes_left_q <= '0;
    end else begin
      in_frame_q   <= in_frame_d;
      bytes_left_q <= bytes_left_d;
    end
  end

endmodule

// ----- rtl/cpf_fifo.sv -----
`timescale 1ns / 1ps

module cpf_fifo
  import cpf_pkg::*;
#(
  parameter int unsigned Depth = CPF_FIFO_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/cpf_back.sv -----
`timescale 1ns / 1ps

module cpf_back
  import cpf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  cmd_t        q_cmd_i,
  output logic        q_pop_o,
  input  logic [7:0]  version_i,
  input  logic [15:0] crc_seed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o,
  output logic        run_last_o,
  output logic [1:0]  status_o
);

  logic [3:0]  pos_q;
  logic [15:0] crc_q, crc_d;
  logic        emit;
  logic [7:0]  byte_d;
  logic        end_d, last_d;
  logic [1:0]  status_d;
  logic [7:0]  hdr_byte;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        frame_end_q, run_last_q;
  logic [1:0]  status_q;

  assign emit    = !q_empty_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = emit && last_d;

  always_comb begin
    unique case (pos_q)
      4'd0:    hdr_byte = SYNC_0;
      4'd1:    hdr_byte = SYNC_1;
      4'd2:    hdr_byte = version_i;
      4'd3:    hdr_byte = q_cmd_i.message_type;
      4'd4:    hdr_byte = q_cmd_i.payload_length[7:0];
      4'd5:    hdr_byte = q_cmd_i.payload_length[15:8];
      4'd6:    hdr_byte = q_cmd_i.sequence_req[7:0];
      4'd7:    hdr_byte = q_cmd_i.sequence_req[15:8];
      4'd8:    hdr_byte = q_cmd_i.sequence_req[23:16];
      4'd9:    hdr_byte = q_cmd_i.sequence_req[31:24];
      4'd10:   hdr_byte = q_cmd_i.timestamp_ms[7:0];
      4'd11:   hdr_byte = q_cmd_i.timestamp_ms[15:8];
      4'd12:   hdr_byte = q_cmd_i.timestamp_ms[23:16];
      4'd13:   hdr_byte = q_cmd_i.timestamp_ms[31:24];
      default: hdr_byte = 8'h00;
    endcase
  end

  always_comb begin
    byte_d   = 8'h00;
    end_d    = 1'b0;
    last_d   = 1'b1;
    status_d = STATUS_OK;
    crc_d    = crc_q;
    unique case (q_cmd_i.op)
      CMD_START: begin
        last_d = q_cmd_i.crc_after ? (pos_q == POS_HDR_CRCH) : (pos_q == POS_HDR_LAST);
        if (pos_q == POS_HDR_CRCL) begin
          byte_d = crc_q[7:0];
        end else if (pos_q == POS_HDR_CRCH) begin
          byte_d = crc_q[15:8];
          end_d  = 1'b1;
        end else begin
          byte_d = hdr_byte;
          // sync bytes are outside the crc
          crc_d  = (pos_q <= POS_SYNC_1) ? crc_seed_i : crc_byte(crc_q, hdr_byte);
        end
      end
      CMD_DATA: begin
        last_d = q_cmd_i.crc_after ? (pos_q == POS_DAT_CRCH) : (pos_q == POS_DAT_BYTE);
        if (pos_q == POS_DAT_BYTE) begin
          byte_d = q_cmd_i.payload_byte;
          crc_d  = crc_byte(crc_q, q_cmd_i.payload_byte);
        end else if (pos_q == POS_DAT_CRCL) begin
          byte_d = crc_q[7:0];
        end else begin
          byte_d = crc_q[15:8];
          end_d  = 1'b1;
        end
      end
      CMD_ERR_LEN:   status_d = STATUS_LEN_LARGE;
      CMD_ERR_FRAME: status_d = STATUS_NO_FRAME;
      default:       status_d = STATUS_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      crc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        pos_q <= last_d ? '0 : pos_q + 4'd1;
        crc_q <= crc_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q  <= byte_d;
      frame_end_q <= end_d;
      run_last_q  <= last_d;
      status_q    <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign frame_end_o = frame_end_q;
  assign run_last_o  = run_last_q;
  assign status_o    = status_q;

endmodule

// ----- rtl/crc16_packet_framer_top.sv -----
`timescale 1ns / 1ps

// Telemetry frame builder with CRC-16 (poly 0x1021, msb first). A start word
// (tuser 0) produces a 14-byte header (A5 5A, version, type, length LE16,
// sequence LE32, timestamp LE32) and, for a zero length, the two CRC bytes
// right after; each payload word (tuser 1) passes one byte and the last one
// of the frame is followed by the CRC, low byte first. Rejected starts and
// payload outside a frame give one status-only word. The front end takes one
// input word per cycle into a command queue; the back end serializes one
// output byte per cycle while the output is ready, so a payload or status
// word gives one output byte, a start 14 and a frame's closing word two more
// for the CRC. Input is held back only when the command queue is full. The
// user must write configuration only while the block is idle (not enforced).
module crc16_packet_framer_top
  import cpf_pkg::*;
#(
  parameter int unsigned FifoDepth = CPF_FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // message_type[7:0], sequence_req[39:8], timestamp_ms[71:40],
  // payload_length[87:72], payload_byte[95:88]
  input  logic [95:0] s_axis_tdata,
  // kind[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte[7:0]
  output logic [7:0]  m_axis_tdata,
  // frame_end
  output logic        m_axis_tlast,
  // run_last[0], status[2:1]
  output logic [2:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [7:0]  version_q;
  logic [15:0] max_payload_q;
  logic [15:0] crc_seed_q;

  logic q_full, q_empty, q_push, q_pop;
  cmd_t push_cmd, head_cmd;
  logic run_last;
  logic [1:0] status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q     <= RST_VERSION;
      max_payload_q <= RST_MAX_PAYLOAD;
      crc_seed_q    <= RST_CRC_SEED;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_VERSION:     version_q     <= cfg_data_i[7:0];
        REG_MAX_PAYLOAD: max_payload_q <= cfg_data_i;
        REG_CRC_SEED:    crc_seed_q    <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  cpf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .kind_i           (s_axis_tuser),
    .message_type_i   (s_axis_tdata[7:0]),
    .sequence_req_i   (s_axis_tdata[39:8]),
    .timestamp_ms_i   (s_axis_tdata[71:40]),
    .payload_length_i (s_axis_tdata[87:72]),
    .payload_byte_i   (s_axis_tdata[95:88]),
    .max_payload_i    (max_payload_q),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_cmd_o          (push_cmd)
  );

  cpf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (head_cmd)
  );

  cpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (q_pop),
    .version_i   (version_q),
    .crc_seed_i  (crc_seed_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .frame_end_o (m_axis_tlast),
    .run_last_o  (run_last),
    .status_o    (status)
  );

  assign m_axis_tuser = {status, run_last};

endmodule
